/* sv/timestamp_event_builder_top_defines.svh */
// Assertion macros shared by the timestamp event builder modules.
`ifndef TIMESTAMP_EVENT_BUILDER_TOP_DEFINES_SVH
`define TIMESTAMP_EVENT_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TEB_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/teb_pkg.sv */
// Shared types, constants and helpers of the timestamp event builder.
package teb_pkg;

  // Detector slots per event
  localparam int NUM_DETECTORS = 5;
  localparam int SLOT_W        = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
  localparam int SLOW_COUNT    = (NUM_DETECTORS < 4) ? NUM_DETECTORS : 4;

  // Word layout
  localparam int WORD_W   = 32;
  localparam int STAMP_W  = 48;
  localparam int IDENT_W  = 12;
  localparam int ADC_W    = 16;
  localparam int ENERGY_W = 17;
  localparam int TIME_W   = 64;
  localparam int SCALED_W = 63;
  localparam int DET_W    = 3;

  localparam logic [WORD_W-1:0] FILL_WORD = 32'h5e5e_5e5e;
  localparam logic [WORD_W-1:0] ONES_WORD = 32'hffff_ffff;
  localparam logic [WORD_W-1:0] DATA_MASK = 32'hc000_0000;
  localparam logic [WORD_W-1:0] SYNC_MASK = 32'hc0f0_0000;
  localparam logic [WORD_W-1:0] SYNC_CODE = 32'h8040_0000;
  localparam logic [6:0]        CARD_SKIP = 7'd99;

  localparam logic [IDENT_W-1:0] SLOW_BASE = 12'd64;
  localparam logic [IDENT_W-1:0] FAST_BASE = 12'd72;
  localparam logic [IDENT_W-1:0] TIME_BASE = 12'd88;

  localparam logic [2:0]  COARSE_SKIP = 3'd7;
  localparam logic [14:0] STAMP_SCALE = 15'd25000;

  // Configuration
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_GUARD   = 1'd1;
  localparam logic [15:0] WINDOW_RESET = 16'd9;
  localparam logic [27:0] GUARD_RESET  = 28'd26;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    HIT_NONE,
    HIT_SLOW,
    HIT_FAST,
    HIT_TIME
  } hit_kind_e;

  typedef struct packed {
    logic [15:0] event_window;
    logic [27:0] wrap_guard;
  } teb_cfg_t;

  // One queued request: close flag, hit to store, scaled stamp
  typedef struct packed {
    logic                close;
    hit_kind_e           kind;
    logic [SLOT_W-1:0]   slot;
    logic [ADC_W-1:0]    adc;
    logic [SCALED_W-1:0] scaled;
  } teb_op_t;

  // coarse * 5000
  function automatic logic [15:0] coarse_offset(input logic [2:0] coarse);
    logic [15:0] off;
    case (coarse)
      3'd0:    off = 16'd0;
      3'd1:    off = 16'd5000;
      3'd2:    off = 16'd10000;
      3'd3:    off = 16'd15000;
      3'd4:    off = 16'd20000;
      3'd5:    off = 16'd25000;
      3'd6:    off = 16'd30000;
      default: off = 16'd35000;
    endcase
    return off;
  endfunction

endpackage

/* sv/timestamp_event_builder_top.sv */
// Top level: configuration registers, front end, request queue, back end.
// The front takes one word pair per cycle while its stage is free or leaving; a data pair
// is registered in that stage, then offered to the queue if it closes or stores a hit.
// The back end pops a plain hit store from idle; for a closing request it emits one result
// per cycle while the output is free, one per detector slot, and pops with the last.
// rst_ni (async, active low): window 9, guard 26, stamps 0, all slots -1.
module timestamp_event_builder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [teb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // ts_low, data_word
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [teb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // detector, slow_energy,
                                                           // fast_energy, hit_time, pad
  output logic                             m_axis_tlast,   // last_slot
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [teb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [teb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import teb_pkg::*;

  teb_cfg_t cfg_q;
  teb_op_t  fq_op, qb_op;
  logic     fq_valid, fq_ready, qb_valid, qb_pop;

  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.event_window <= WINDOW_RESET;
      cfg_q.wrap_guard   <= GUARD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EVENT_WINDOW: cfg_q.event_window <= cfg_data_i[15:0];
        CFG_WRAP_GUARD:   cfg_q.wrap_guard   <= cfg_data_i[27:0];
        default: ;
      endcase
    end
  end

  teb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .op_valid_o    (fq_valid),
    .op_ready_i    (fq_ready),
    .op_o          (fq_op)
  );

  teb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_valid),
    .ready_o (fq_ready),
    .op_i    (fq_op),
    .valid_o (qb_valid),
    .pop_i   (qb_pop),
    .op_o    (qb_op)
  );

  teb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (qb_valid),
    .op_pop_o      (qb_pop),
    .op_i          (qb_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* sv/teb_front.sv */
// Front end: takes word pairs, rebuilds the stamp, decides event close.
module teb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  teb_pkg::teb_cfg_t               cfg_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [teb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // ts_low, data_word
  output logic                            op_valid_o,
  input  logic                            op_ready_i,
  output teb_pkg::teb_op_t                op_o
);
  import teb_pkg::*;

  logic [WORD_W-1:0]  lo, dw;
  logic [IDENT_W-1:0] ident, slow_off, fast_off, time_off;
  logic [ADC_W-1:0]   adc;
  logic               accept, is_filler, is_data, is_sync, data_take, wrap_hit;
  logic [STAMP_W-1:0] merged, wrapped, data_stamp, sync_stamp;
  hit_kind_e          kind;
  logic [SLOT_W-1:0]  slot;

  logic [STAMP_W-1:0] cur_q, cur_d, prev_q, prev_d;
  logic               wrap_done_q, wrap_done_d;

  logic               st_valid_q, st_valid_d;
  logic [STAMP_W-1:0] st_stamp_q;
  hit_kind_e          st_kind_q;
  logic [SLOT_W-1:0]  st_slot_q;
  logic [ADC_W-1:0]   st_adc_q;

  logic [STAMP_W+1:0]  diff;
  logic                close, needs_push, st_leave;
  logic [SCALED_W-1:0] scaled;

  assign lo     = s_axis_tdata[WORD_W-1:0];
  assign dw     = s_axis_tdata[2*WORD_W-1:WORD_W];
  assign accept = s_axis_tvalid && s_axis_tready;

  // Pair classification
  assign is_filler = ((lo == '0) && (dw == '0)) ||
                     ((lo == FILL_WORD) && ((dw == FILL_WORD) || (dw == ONES_WORD)));
  assign is_data   = (dw & DATA_MASK) == DATA_MASK;
  assign is_sync   = (dw & SYNC_MASK) == SYNC_CODE;
  assign ident     = dw[27:16];
  assign adc       = dw[15:0];
  assign data_take = !is_filler && is_data && (ident[11:5] != CARD_SKIP);

  // Stamp rebuild; low word bits 31..28 overlap the stored high part
  assign merged     = {cur_q[47:32], cur_q[31:28] | lo[31:28], lo[27:0]};
  assign wrap_hit   = (lo <= {4'b0, cfg_i.wrap_guard}) && !wrap_done_q;
  assign wrapped    = {merged[47:28] + 20'd1, merged[27:0]};
  assign data_stamp = wrap_hit ? wrapped : merged;
  assign sync_stamp = {dw[19:4], dw[3:0] | lo[31:28], lo[27:0]};

  // Hit kind by ident range
  assign slow_off = ident - SLOW_BASE;
  assign fast_off = ident - FAST_BASE;
  assign time_off = ident - TIME_BASE;

  always_comb begin
    kind = HIT_NONE;
    slot = '0;
    if (slow_off < IDENT_W'(SLOW_COUNT)) begin
      kind = HIT_SLOW;
      slot = slow_off[SLOT_W-1:0];
    end else if (fast_off < IDENT_W'(NUM_DETECTORS)) begin
      kind = HIT_FAST;
      slot = fast_off[SLOT_W-1:0];
    end else if ((time_off < IDENT_W'(NUM_DETECTORS)) && (adc[15:13] != COARSE_SKIP)) begin
      kind = HIT_TIME;
      slot = time_off[SLOT_W-1:0];
    end
  end

  // Stage two: step against previous data stamp
  assign diff       = {2'b00, st_stamp_q} - {2'b00, prev_q};
  assign close      = !diff[STAMP_W+1] && (diff[STAMP_W:0] >= (STAMP_W+1)'(cfg_i.event_window));
  assign scaled     = SCALED_W'(st_stamp_q) * SCALED_W'(STAMP_SCALE);
  assign needs_push = close || (st_kind_q != HIT_NONE);
  assign st_leave   = st_valid_q && (!needs_push || op_ready_i);

  assign s_axis_tready = !st_valid_q || st_leave;
  assign op_valid_o    = st_valid_q && needs_push;
  assign op_o.close    = close;
  assign op_o.kind     = st_kind_q;
  assign op_o.slot     = st_slot_q;
  assign op_o.adc      = st_adc_q;
  assign op_o.scaled   = scaled;

  // Stamp state updates
  always_comb begin
    cur_d       = cur_q;
    wrap_done_d = wrap_done_q;
    prev_d      = prev_q;
    st_valid_d  = st_valid_q;
    if (st_leave) begin
      prev_d     = st_stamp_q;
      st_valid_d = 1'b0;
    end
    if (accept && data_take) begin
      cur_d      = data_stamp;
      st_valid_d = 1'b1;
      if (wrap_hit) begin
        wrap_done_d = 1'b1;
      end
    end else if (accept && !is_filler && is_sync) begin
      cur_d       = sync_stamp;
      wrap_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      prev_q      <= '0;
      wrap_done_q <= 1'b0;
      st_valid_q  <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      wrap_done_q <= wrap_done_d;
      st_valid_q  <= st_valid_d;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept && data_take) begin
      st_stamp_q <= data_stamp;
      st_kind_q  <= kind;
      st_slot_q  <= slot;
      st_adc_q   <= adc;
    end
  end

endmodule

/* sv/teb_queue.sv */
// Short request queue between front and back ends.
`include "timestamp_event_builder_top_defines.svh"
module teb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  teb_pkg::teb_op_t op_i,
  output logic             valid_o,
  input  logic             pop_i,
  output teb_pkg::teb_op_t op_o
);
  import teb_pkg::*;

  teb_op_t            mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] count_q;
  logic               push, pop;

  assign ready_o = count_q != Q_CNT_W'(Q_DEPTH);
  assign valid_o = count_q != '0;
  assign push    = push_i && ready_o;
  assign pop     = pop_i && valid_o;
  assign op_o    = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - Q_CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  `TEB_ASSERT_HOLD(a_cnt_range, 1'b1, count_q <= Q_CNT_W'(Q_DEPTH), "queue count overflow")
  `TEB_ASSERT_NEXT(a_cnt_up, push && !pop, count_q == $past(count_q) + Q_CNT_W'(1), "push lost")
  `TEB_ASSERT_HOLD(a_empty_ptr, count_q == '0, wr_q == rd_q, "empty queue pointers differ")

endmodule

/* sv/teb_back.sv */
// Back end: holds detector slots, emits closed events, stores hits.
`include "timestamp_event_builder_top_defines.svh"
module teb_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             op_valid_i,
  output logic                             op_pop_o,
  input  teb_pkg::teb_op_t                 op_i,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [teb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // detector, slow_energy,
                                                          // fast_energy, hit_time, pad
  output logic                             m_axis_tlast   // last_slot
);
  import teb_pkg::*;

  localparam logic [0:0] B_IDLE = 1'b0;
  localparam logic [0:0] B_EMIT = 1'b1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_DETECTORS - 1);

  logic [0:0]        state_q, state_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;

  logic signed [ENERGY_W-1:0] slow_q [NUM_DETECTORS];
  logic signed [ENERGY_W-1:0] fast_q [NUM_DETECTORS];
  logic signed [TIME_W-1:0]   time_q [NUM_DETECTORS];

  logic                       out_valid_q, out_valid_d, out_last_q;
  logic [DET_W-1:0]           out_det_q;
  logic [ENERGY_W-1:0]        out_slow_q, out_fast_q;
  logic [TIME_W-1:0]          out_time_q;

  logic                out_free, emit, store, clear;
  logic [16:0]         off_sum;
  logic [TIME_W-1:0]   time_val;

  assign out_free = !out_valid_q || m_axis_tready;

  // Hit time: scaled stamp plus coarse and fine parts
  assign off_sum  = 17'(coarse_offset(op_i.adc[15:13])) + 17'(op_i.adc[12:0]);
  assign time_val = {1'b0, op_i.scaled} + TIME_W'(off_sum);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    op_pop_o = 1'b0;
    emit     = 1'b0;
    store    = 1'b0;
    clear    = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (op_valid_i) begin
          if (op_i.close) begin
            state_d = B_EMIT;
            cnt_d   = '0;
          end else begin
            store    = 1'b1;
            op_pop_o = 1'b1;
          end
        end
      end
      B_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (cnt_q == LAST_SLOT) begin
            clear    = 1'b1;
            store    = 1'b1;
            op_pop_o = 1'b1;
            state_d  = B_IDLE;
          end else begin
            cnt_d = cnt_q + SLOT_W'(1);
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Detector slots: the new hit wins over the clear on close
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_DETECTORS; j++) begin
        slow_q[j] <= '1;
        fast_q[j] <= '1;
        time_q[j] <= '1;
      end
    end else begin
      for (int j = 0; j < NUM_DETECTORS; j++) begin
        if (store && (op_i.slot == SLOT_W'(j)) && (op_i.kind == HIT_SLOW)) begin
          slow_q[j] <= {1'b0, op_i.adc};
        end else if (clear) begin
          slow_q[j] <= '1;
        end
        if (store && (op_i.slot == SLOT_W'(j)) && (op_i.kind == HIT_FAST)) begin
          fast_q[j] <= {1'b0, op_i.adc};
        end else if (clear) begin
          fast_q[j] <= '1;
        end
        if (store && (op_i.slot == SLOT_W'(j)) && (op_i.kind == HIT_TIME)) begin
          time_q[j] <= time_val;
        end else if (clear) begin
          time_q[j] <= '1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_det_q  <= DET_W'(cnt_q) + DET_W'(1);
      out_slow_q <= slow_q[cnt_q];
      out_fast_q <= fast_q[cnt_q];
      out_time_q <= time_q[cnt_q];
      out_last_q <= cnt_q == LAST_SLOT;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, out_time_q, out_fast_q, out_slow_q, out_det_q};

  `TEB_ASSERT_HOLD(a_cnt_range, state_q == B_EMIT, cnt_q <= LAST_SLOT, "slot counter overrun")
  `TEB_ASSERT_HOLD(a_pop_valid, op_pop_o, op_valid_i, "pop from empty queue")
  `TEB_ASSERT_HOLD(a_last_det, m_axis_tvalid && m_axis_tlast, out_det_q == DET_W'(NUM_DETECTORS), "last flag on wrong slot")

endmodule

/* dv/timestamp_event_builder_top_tb.sv */
// Self-checking testbench for the timestamp event builder top level.
`timescale 1ns / 100ps

module timestamp_event_builder_top_tb;
  import teb_pkg::*;

  localparam int          HALF_PERIOD   = 6;
  localparam int          RESET_CYCLES  = 4;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          PHASE_ITEMS   = 75;
  localparam int          PHASE_COUNT   = 6;
  localparam logic [47:0] HIGH_PART     = 48'hffff_f000_0000;
  localparam logic [47:0] WRAP_STEP     = 48'h0000_1000_0000;

  // One closed-event slot as it leaves the block
  typedef struct packed {
    logic [DET_W-1:0]    detector;
    logic [ENERGY_W-1:0] slow_energy;
    logic [ENERGY_W-1:0] fast_energy;
    logic [TIME_W-1:0]   hit_time;
    logic                last_slot;
  } slot_result_t;

  // Event builder predictor plus the queue of slot results still owed
  class event_slot_tracker;
    bit [15:0]         window;
    bit [27:0]         guard;
    bit [STAMP_W-1:0]  cur_stamp;
    bit [STAMP_W-1:0]  prev_stamp;
    bit                wrap_done;
    bit [ENERGY_W-1:0] slow_slot [NUM_DETECTORS];
    bit [ENERGY_W-1:0] fast_slot [NUM_DETECTORS];
    bit [TIME_W-1:0]   time_slot [NUM_DETECTORS];
    slot_result_t      owed_slots[$];
    int                mismatch_count;

    function new();
      window         = WINDOW_RESET;
      guard          = GUARD_RESET;
      cur_stamp      = '0;
      prev_stamp     = '0;
      wrap_done      = 1'b0;
      mismatch_count = 0;
      empty_slots();
    endfunction

    function void empty_slots();
      for (int j = 0; j < NUM_DETECTORS; j++) begin
        slow_slot[j] = '1;
        fast_slot[j] = '1;
        time_slot[j] = '1;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_EVENT_WINDOW) window = val[15:0];
      else if (idx == CFG_WRAP_GUARD) guard = val[27:0];
    endfunction

    // Accepted word pair: update stamps, close the event, store the hit
    function void absorb_pair(logic [IN_TDATA_W-1:0] pair);
      logic [31:0]        lo;
      logic [31:0]        dw;
      logic [IDENT_W-1:0] ident;
      logic [ADC_W-1:0]   adc;
      logic [2:0]         coarse;
      longint             stride;
      slot_result_t       res;
      lo = pair[31:0];
      dw = pair[63:32];
      if (lo == '0 && dw == '0) return;
      if (lo == FILL_WORD && (dw == FILL_WORD || dw == ONES_WORD)) return;
      if ((dw & DATA_MASK) == DATA_MASK) begin
        ident = dw[27:16];
        adc   = dw[15:0];
        if (ident[11:5] == CARD_SKIP) return;
        cur_stamp = (cur_stamp & HIGH_PART) | {16'h0, lo};
        if ({4'h0, guard} >= lo && !wrap_done) begin
          cur_stamp = cur_stamp + WRAP_STEP;
          wrap_done = 1'b1;
        end
        stride = longint'({16'h0, cur_stamp}) - longint'({16'h0, prev_stamp});
        if (stride >= longint'({48'h0, window})) begin
          for (int j = 0; j < NUM_DETECTORS; j++) begin
            res.detector    = DET_W'(j + 1);
            res.slow_energy = slow_slot[j];
            res.fast_energy = fast_slot[j];
            res.hit_time    = time_slot[j];
            res.last_slot   = (j == NUM_DETECTORS - 1);
            owed_slots.push_back(res);
          end
          empty_slots();
        end
        // Hit store by ident range
        if (ident >= SLOW_BASE && ident < SLOW_BASE + SLOW_COUNT)
          slow_slot[ident - SLOW_BASE] = {1'b0, adc};
        if (ident >= FAST_BASE && ident < FAST_BASE + NUM_DETECTORS)
          fast_slot[ident - FAST_BASE] = {1'b0, adc};
        if (ident >= TIME_BASE && ident < TIME_BASE + NUM_DETECTORS) begin
          coarse = adc[15:13];
          if (coarse != COARSE_SKIP)
            time_slot[ident - TIME_BASE] = {16'h0, cur_stamp} * 64'd25000 +
                                           64'(coarse) * 64'd5000 + 64'(adc[12:0]);
        end
        prev_stamp = cur_stamp;
      end else if ((dw & SYNC_MASK) == SYNC_CODE) begin
        cur_stamp = {dw[19:0], 28'h0} | {16'h0, lo};
        wrap_done = 1'b0;
      end
    endfunction

    function void compare_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatch_count++;
        $display("%0t %s mismatch: expected %h, actual %h", $time, label, want, got);
      end
    endfunction

    // Accepted slot result against the oldest owed one
    function void match_slot_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      slot_result_t want;
      if (owed_slots.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none, actual %h last %b",
                 $time, tdata, tlast);
        return;
      end
      want = owed_slots.pop_front();
      compare_field("detector",    64'(want.detector),    64'(tdata[2:0]));
      compare_field("slow_energy", 64'(want.slow_energy), 64'(tdata[19:3]));
      compare_field("fast_energy", 64'(want.fast_energy), 64'(tdata[36:20]));
      compare_field("hit_time",    want.hit_time,         tdata[100:37]);
      compare_field("last_slot",   64'(want.last_slot),   64'(tlast));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // ts_low, data_word
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // detector, slow_energy, fast_energy, hit_time, pad
  logic                   m_axis_tlast;   // last_slot
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  event_slot_tracker tracker = new();

  int          src_idle_pct;
  int          snk_idle_pct;
  int          cycle_count;
  logic [31:0] lo_cursor;
  logic [15:0] cur_window;
  logic [27:0] cur_guard;

  timestamp_event_builder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[timestamp_event_builder_top] ERROR");
      $finish;
    end
  end

  // Result side: check accepted slots, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.match_slot_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  function automatic logic [31:0] data_word(logic [IDENT_W-1:0] ident, logic [ADC_W-1:0] adc);
    return {DATA_MASK[31:30], 2'b00, ident, adc};
  endfunction

  function automatic logic [31:0] sync_word(logic [19:0] high_bits);
    return SYNC_CODE | {12'h0, high_bits};
  endfunction

  // Random word pair, mostly well-formed hit streams
  function automatic logic [IN_TDATA_W-1:0] next_pair();
    int                 pick;
    int                 span;
    logic [31:0]        lo;
    logic [31:0]        dw;
    logic [IDENT_W-1:0] ident;
    pick = $urandom_range(0, 99);
    span = int'(cur_window) * 2 + 2;
    if (pick < 8) begin
      // sync, then restart the low stamp, often inside the wrap guard
      lo = $urandom;
      dw = ($urandom & ~SYNC_MASK) | SYNC_CODE;
      lo_cursor = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, cur_guard))
                                              : 32'($urandom_range(0, 4095));
    end else if (pick < 80) begin
      case ($urandom_range(0, 15))
        0:       lo_cursor = $urandom;
        1:       lo_cursor = lo_cursor - 32'($urandom_range(0, span));
        default: lo_cursor = lo_cursor + 32'($urandom_range(0, span));
      endcase
      lo = lo_cursor;
      case ($urandom_range(0, 2))
        0:       ident = SLOW_BASE + IDENT_W'($urandom_range(0, NUM_DETECTORS));
        1:       ident = FAST_BASE + IDENT_W'($urandom_range(0, NUM_DETECTORS));
        default: ident = TIME_BASE + IDENT_W'($urandom_range(0, NUM_DETECTORS));
      endcase
      dw = data_word(ident, ADC_W'($urandom)) | {2'b00, 2'($urandom), 28'h0};
    end else if (pick < 86) begin
      lo_cursor = lo_cursor + 32'($urandom_range(0, span));
      lo = lo_cursor;
      dw = data_word(IDENT_W'($urandom), ADC_W'($urandom));
    end else if (pick < 89) begin
      lo = $urandom;
      dw = data_word({CARD_SKIP, 5'($urandom)}, ADC_W'($urandom));
    end else if (pick < 93) begin
      case ($urandom_range(0, 2))
        0:       begin lo = '0;        dw = '0;        end
        1:       begin lo = FILL_WORD; dw = FILL_WORD; end
        default: begin lo = FILL_WORD; dw = ONES_WORD; end
      endcase
    end else begin
      lo = $urandom;
      dw = $urandom;
    end
    return {dw, lo};
  endfunction

  task automatic send_pair(input logic [IN_TDATA_W-1:0] pair);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pair;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.absorb_pair(pair);
  endtask

  task automatic send_data(input logic [31:0] lo, input logic [IDENT_W-1:0] ident,
                           input logic [ADC_W-1:0] adc);
    send_pair({data_word(ident, adc), lo});
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tracker.write_register(idx, val);
    if (idx == CFG_EVENT_WINDOW) cur_window = val[15:0];
    else cur_guard = val[27:0];
    @(posedge clk_i);
  endtask

  // Stop sending, drain owed slots, let the back end finish its last store
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.owed_slots.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] win;
    logic [27:0] grd;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_EVENT_WINDOW;
    cfg_data_i    = '0;
    cycle_count   = 0;
    lo_cursor     = '0;
    cur_window    = WINDOW_RESET;
    cur_guard     = GUARD_RESET;
    src_idle_pct  = 35;
    snk_idle_pct  = 67;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fillers, every slot kind, skips, sync and wrap, low word overlap
    send_pair({32'h0, 32'h0});
    send_pair({FILL_WORD, FILL_WORD});
    send_pair({ONES_WORD, FILL_WORD});
    send_data(32'd100, SLOW_BASE, 16'hffff);                       // closes empty event
    send_data(32'd100, SLOW_BASE + 12'd3, 16'h0000);
    send_data(32'd101, FAST_BASE, 16'hffff);
    send_data(32'd102, FAST_BASE + 12'd4, 16'h0001);
    send_data(32'd103, TIME_BASE, {3'd0, 13'h0000});
    send_data(32'd104, TIME_BASE + 12'd4, {3'd6, 13'h1fff});
    send_data(32'd104, TIME_BASE + 12'd1, {COARSE_SKIP, 13'h1234}); // coarse seven
    send_data(32'd105, SLOW_BASE + 12'd4, 16'h5555);                // no slow slot five
    send_data(32'hffff_ffff, {CARD_SKIP, 5'd31}, 16'h7777);          // card skip
    send_data(32'd106, 12'hfff, 16'h2222);
    send_data(32'd107, SLOW_BASE, 16'h1234);                        // overwrite
    send_pair({32'h4000_0000, 32'd5000});                           // neither data nor sync
    send_data(32'd120, FAST_BASE + 12'd1, 16'habcd);                // closes filled event
    send_pair({sync_word(20'hfffff), 32'd5});
    send_data(32'd3, TIME_BASE + 12'd2, {3'd1, 13'h0001});           // wrap past 2^48
    send_data(32'hffff_ffff, SLOW_BASE + 12'd1, 16'h00ff);           // overlap, closes
    send_data(32'd0, FAST_BASE + 12'd2, 16'h8000);                  // no second wrap
    send_pair({sync_word(20'h00000), 32'd0});
    send_data(32'd0, TIME_BASE + 12'd3, {3'd5, 13'h0abc});           // wrap, no close
    settle();

    // Random phases over a range of settings
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       begin win = 16'hffff;                  grd = 28'hfff_ffff;               end
        1:       begin win = 16'd1;                     grd = 28'd0;                      end
        2:       begin win = 16'd0;                     grd = 28'($urandom_range(0, 500)); end
        3:       begin win = 16'($urandom_range(1, 64)); grd = 28'($urandom_range(0, 2000)); end
        4:       begin win = WINDOW_RESET;              grd = GUARD_RESET;                end
        default: begin win = 16'($urandom_range(1, 65535)); grd = 28'($urandom);          end
      endcase
      case (p)
        0, 1:    begin src_idle_pct = 35; snk_idle_pct = 67; end
        2, 3:    begin src_idle_pct = 67; snk_idle_pct = 35; end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      write_register(CFG_EVENT_WINDOW, {16'h0, win});
      write_register(CFG_WRAP_GUARD, {4'h0, grd});
      for (int k = 0; k < PHASE_ITEMS; k++) send_pair(next_pair());
      settle();
    end

    if (tracker.mismatch_count == 0) begin
      $display("[timestamp_event_builder_top] OK");
    end else begin
      $display("[timestamp_event_builder_top] ERROR");
    end
    $finish;
  end

endmodule

/* timestamp_event_builder_top.f */
+incdir+sv
sv/teb_pkg.sv
sv/teb_front.sv
sv/teb_queue.sv
sv/teb_back.sv
sv/timestamp_event_builder_top.sv
dv/timestamp_event_builder_top_tb.sv
